FILE: rtl/jbt_pkg.sv
// Shared types and constants for the JSON byte tokenizer.
// Token kind codes, character codes, keyword tables, result record types.
// No dependencies.
`timescale 1ns / 1ps

package jbt_pkg;

	localparam logic [3:0] K_SPACE  = 4'd0;
	localparam logic [3:0] K_NUMBER = 4'd1;
	localparam logic [3:0] K_LBRACK = 4'd2;
	localparam logic [3:0] K_RBRACK = 4'd3;
	localparam logic [3:0] K_LBRACE = 4'd4;
	localparam logic [3:0] K_RBRACE = 4'd5;
	localparam logic [3:0] K_COMMA  = 4'd6;
	localparam logic [3:0] K_COLON  = 4'd7;
	localparam logic [3:0] K_STRING = 4'd8;
	localparam logic [3:0] K_BOOL   = 4'd9;
	localparam logic [3:0] K_NULL   = 4'd10;
	localparam logic [3:0] K_UNDEF  = 4'd11;
	localparam logic [3:0] K_END    = 4'd12;
	localparam logic [3:0] K_ERROR  = 4'd13;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;
	localparam logic [1:0] KW_UNDEF = 2'd3;

	// keyword spellings, first letter in the top byte
	localparam logic [71:0] KW_TEXT_TRUE  = {"true", 40'h0};
	localparam logic [71:0] KW_TEXT_FALSE = {"false", 32'h0};
	localparam logic [71:0] KW_TEXT_NULL  = {"null", 40'h0};
	localparam logic [71:0] KW_TEXT_UNDEF = "undefined";

	typedef struct packed {
		logic [3:0]         kind;
		logic [31:0]        start;
		logic [31:0]        length;
		logic signed [63:0] value;
		logic               frac;
		logic               bval;
		logic               last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	function automatic logic [3:0] kw_len(logic [1:0] c);
		logic [3:0] l;
		unique case (c)
			KW_TRUE:  l = 4'd4;
			KW_FALSE: l = 4'd5;
			KW_NULL:  l = 4'd4;
			default:  l = 4'd9;
		endcase
		return l;
	endfunction

	function automatic logic [3:0] kw_kind(logic [1:0] c);
		logic [3:0] k;
		unique case (c)
			KW_TRUE, KW_FALSE: k = K_BOOL;
			KW_NULL:           k = K_NULL;
			default:           k = K_UNDEF;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] kw_char(logic [1:0] c, logic [3:0] i);
		logic [71:0] w;
		logic [71:0] sh;
		unique case (c)
			KW_TRUE:  w = KW_TEXT_TRUE;
			KW_FALSE: w = KW_TEXT_FALSE;
			KW_NULL:  w = KW_TEXT_NULL;
			default:  w = KW_TEXT_UNDEF;
		endcase
		sh = w << {i, 3'b000};
		return (i > 4'd8) ? 8'h00 : sh[71:64];
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

endpackage

FILE: rtl/jbt_byte_if.sv
// Byte channel into the tokenizer: valid/ready handshake with one text byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface jbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

FILE: rtl/jbt_token_if.sv
// Token channel out of the tokenizer: valid/ready handshake with one token.
// Depends on nothing.
`timescale 1ns / 1ps

interface jbt_token_if;
	logic               valid;
	logic               ready;
	logic [3:0]         token_kind;
	logic [31:0]        token_start;
	logic [31:0]        token_length;
	logic signed [63:0] integer_value;
	logic               has_fraction;
	logic               bool_value;
	logic               last_result;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output integer_value, output has_fraction,
		output bool_value, output last_result, input ready);
	modport sink (input valid, input token_kind, input token_start,
		input token_length, input integer_value, input has_fraction,
		input bool_value, input last_result, output ready);
endinterface

FILE: rtl/jbt_lexer.sv
// Lexer stage: input byte register, scan state and the per-byte next-state
// and token logic. Uses jbt_pkg; hands up to two tokens per byte to the queue.
`timescale 1ns / 1ps

module jbt_lexer import jbt_pkg::*; #(
	parameter int OB = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       room,
	output push_t      push
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_SPACE   = 3'd1;
	localparam logic [2:0] MODE_NUMBER  = 3'd2;
	localparam logic [2:0] MODE_STRING  = 3'd3;
	localparam logic [2:0] MODE_KEYWORD = 3'd4;

	localparam logic [OB-1:0] ONE = OB'(1);
	localparam logic [63:0]   OVF = 64'h8000_0000_0000_0000;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          adv;

	logic [2:0]    mode_q, mode_d;
	logic [OB-1:0] off_q, off_d;
	logic [OB-1:0] org_q, org_d;
	logic [63:0]   acc_q, acc_d;
	logic          frac_q, frac_d;
	logic [1:0]    kch_q, kch_d;
	logic [3:0]    kidx_q, kidx_d;
	logic          skip_q, skip_d;

	token_t        res [2];
	logic [1:0]    n;

	function automatic logic [31:0] to32(logic [OB-1:0] x);
		logic [47:0] w;
		w = 48'(x);
		return w[31:0];
	endfunction

	function automatic token_t mk(logic [3:0] k, logic [OB-1:0] s, logic [OB-1:0] l,
		logic [63:0] v, logic f, logic bv);
		token_t t;
		t.kind   = k;
		t.start  = to32(s);
		t.length = to32(l);
		t.value  = v;
		t.frac   = f;
		t.bval   = bv;
		t.last   = 1'b0;
		return t;
	endfunction

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	always_comb begin
		logic [OB-1:0] span;
		logic          go_idle;
		logic          fail;
		logic [OB-1:0] fail_len;
		logic [66:0]   ext;
		logic [66:0]   mul;
		logic [7:0]    b;

		b        = byte_s1;
		mode_d   = mode_q;
		off_d    = off_q;
		org_d    = org_q;
		acc_d    = acc_q;
		frac_d   = frac_q;
		kch_d    = kch_q;
		kidx_d   = kidx_q;
		skip_d   = skip_q;
		res[0]   = '0;
		res[1]   = '0;
		n        = 2'd0;
		go_idle  = 1'b0;
		fail     = 1'b0;
		fail_len = '0;
		span     = off_q - org_q;
		ext      = 67'(acc_q);
		mul      = (ext << 3) + (ext << 1) + 67'(b - CH_ZERO);

		if (skip_q) begin
			if (b == CH_NUL) begin
				res[0] = mk(K_END, off_q, '0, '0, 1'b0, 1'b0);
				n = 2'd1;
				mode_d = MODE_IDLE;
				off_d = '0; org_d = '0; acc_d = '0; frac_d = 1'b0;
				kch_d = '0; kidx_d = '0; skip_d = 1'b0;
			end else begin
				off_d = off_q + ONE;
			end
		end else begin
			unique case (mode_q)
				MODE_SPACE: begin
					if (is_space(b)) begin
						off_d = off_q + ONE;
					end else begin
						res[0] = mk(K_SPACE, org_q, span, '0, 1'b0, 1'b0);
						n = 2'd1;
						go_idle = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(b)) begin
						if (!frac_q && !acc_q[63]) begin
							acc_d = (|mul[66:63]) ? OVF : mul[63:0];
						end
						off_d = off_q + ONE;
					end else if (b == CH_DOT && !frac_q) begin
						frac_d = 1'b1;
						off_d = off_q + ONE;
					end else if (frac_q) begin
						res[0] = mk(K_NUMBER, org_q, span, '0, 1'b1, 1'b0);
						n = 2'd1;
						go_idle = 1'b1;
					end else if (acc_q[63]) begin
						fail = 1'b1;
						fail_len = span;
					end else begin
						res[0] = mk(K_NUMBER, org_q, span, acc_q, 1'b0, 1'b0);
						n = 2'd1;
						go_idle = 1'b1;
					end
				end
				MODE_STRING: begin
					if (b == CH_QUOTE) begin
						res[0] = mk(K_STRING, org_q, span + ONE, '0, 1'b0, 1'b0);
						n = 2'd1;
						mode_d = MODE_IDLE;
						off_d = off_q + ONE;
					end else if (b == CH_NUL) begin
						fail = 1'b1;
						fail_len = span;
					end else begin
						off_d = off_q + ONE;
					end
				end
				MODE_KEYWORD: begin
					if (kidx_q < kw_len(kch_q) && b == kw_char(kch_q, kidx_q)) begin
						kidx_d = kidx_q + 4'd1;
						if (kidx_d >= kw_len(kch_q)) begin
							res[0] = mk(kw_kind(kch_q), org_q, span + ONE, '0, 1'b0,
								kch_q == KW_TRUE);
							n = 2'd1;
							mode_d = MODE_IDLE;
						end
						off_d = off_q + ONE;
					end else begin
						fail = 1'b1;
						fail_len = (b == CH_NUL) ? span : span + ONE;
					end
				end
				default: go_idle = 1'b1;
			endcase

			// byte opens a new token
			if (go_idle) begin
				mode_d = MODE_IDLE;
				org_d = off_q;
				off_d = off_q + ONE;
				if (b == CH_NUL) begin
					off_d = off_q;
				end else if (is_space(b)) begin
					mode_d = MODE_SPACE;
				end else if (is_digit(b)) begin
					mode_d = MODE_NUMBER;
					acc_d = 64'(b - CH_ZERO);
					frac_d = 1'b0;
				end else if (b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE ||
					b == CH_RBRACE || b == CH_COMMA || b == CH_COLON) begin
					priority case (b)
						CH_LBRACK: res[n[0]] = mk(K_LBRACK, off_q, ONE, '0, 1'b0, 1'b0);
						CH_RBRACK: res[n[0]] = mk(K_RBRACK, off_q, ONE, '0, 1'b0, 1'b0);
						CH_LBRACE: res[n[0]] = mk(K_LBRACE, off_q, ONE, '0, 1'b0, 1'b0);
						CH_RBRACE: res[n[0]] = mk(K_RBRACE, off_q, ONE, '0, 1'b0, 1'b0);
						CH_COMMA:  res[n[0]] = mk(K_COMMA, off_q, ONE, '0, 1'b0, 1'b0);
						default:   res[n[0]] = mk(K_COLON, off_q, ONE, '0, 1'b0, 1'b0);
					endcase
					n = n + 2'd1;
				end else if (b == CH_QUOTE) begin
					mode_d = MODE_STRING;
				end else if (b == CH_T || b == CH_F || b == CH_N || b == CH_U) begin
					mode_d = MODE_KEYWORD;
					priority case (b)
						CH_T:    kch_d = KW_TRUE;
						CH_F:    kch_d = KW_FALSE;
						CH_N:    kch_d = KW_NULL;
						default: kch_d = KW_UNDEF;
					endcase
					kidx_d = 4'd1;
				end else begin
					fail = 1'b1;
					fail_len = ONE;
				end
			end

			// error token always starts at the current token origin
			if (fail) begin
				res[n[0]] = mk(K_ERROR, org_d, fail_len, '0, 1'b0, 1'b0);
				n = n + 2'd1;
				mode_d = MODE_IDLE;
				skip_d = 1'b1;
				off_d = off_q + ONE;
			end

			if (b == CH_NUL && (go_idle || fail)) begin
				res[n[0]] = mk(K_END, off_q, '0, '0, 1'b0, 1'b0);
				n = n + 2'd1;
				mode_d = MODE_IDLE;
				off_d = '0; org_d = '0; acc_d = '0; frac_d = 1'b0;
				kch_d = '0; kidx_d = '0; skip_d = 1'b0;
			end
		end

		if (n == 2'd1) begin
			res[0].last = 1'b1;
		end
		res[1].last = 1'b1;
	end

	assign push.count = adv ? n : 2'd0;
	assign push.tok0  = res[0];
	assign push.tok1  = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			off_q  <= '0;
			org_q  <= '0;
			acc_q  <= '0;
			frac_q <= 1'b0;
			kch_q  <= '0;
			kidx_q <= '0;
			skip_q <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			off_q  <= off_d;
			org_q  <= org_d;
			acc_q  <= acc_d;
			frac_q <= frac_d;
			kch_q  <= kch_d;
			kidx_q <= kidx_d;
			skip_q <= skip_d;
		end
	end

endmodule

FILE: rtl/jbt_token_fifo.sv
// Four-entry token queue: takes up to two tokens a cycle, gives one.
// Uses jbt_pkg for the token and push records.
`timescale 1ns / 1ps

module jbt_token_fifo import jbt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	output logic   room,
	output logic   out_valid,
	input  logic   out_ready,
	output token_t out_tok
);

	token_t     mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign room      = cnt_q <= 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign out_tok   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.tok1;
		end
	end

endmodule

FILE: rtl/json_byte_tokenizer.sv
// Top level of the JSON byte tokenizer: byte channel in, token channel out.
// Uses jbt_pkg, jbt_byte_if, jbt_token_if, jbt_lexer and jbt_token_fifo.
`timescale 1ns / 1ps

// Takes one text byte per cycle and returns tokens (kind, start, length,
// integer value, fraction flag, boolean value) in text order; byte zero closes
// the text with an end token and restarts offsets at zero. A byte enters an
// input register and is scanned from there; its tokens pass through the
// token queue to the sink. Bytes that yield no token or one token flow at one
// per cycle while the token sink is ready. A byte that closes one token and
// also opens a one-byte token, hits an error or ends the text yields two,
// which leave the four-entry token queue at one per cycle while the sink is
// ready; the scan stage takes a byte only when the queue holds two tokens or
// fewer, so an isolated two-token byte is absorbed, while a run of them stalls
// the byte input.
module json_byte_tokenizer import jbt_pkg::*; #(
	parameter int OFFSET_BITS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	jbt_byte_if.sink    text_in,
	jbt_token_if.source token_out
);

	push_t  push;
	logic   room;
	token_t tok;

	jbt_lexer #(
		.OB(OFFSET_BITS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.in_byte  (text_in.text_byte),
		.room     (room),
		.push     (push)
	);

	jbt_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (token_out.valid),
		.out_ready (token_out.ready),
		.out_tok   (tok)
	);

	assign token_out.token_kind    = tok.kind;
	assign token_out.token_start   = tok.start;
	assign token_out.token_length  = tok.length;
	assign token_out.integer_value = tok.value;
	assign token_out.has_fraction  = tok.frac;
	assign token_out.bool_value    = tok.bval;
	assign token_out.last_result   = tok.last;

endmodule

FILE: bench/tb_json_byte_tokenizer.sv
// Self-checking bench for json_byte_tokenizer: drives text bytes, predicts tokens.
// Depends on jbt_pkg, jbt_byte_if, jbt_token_if and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_json_byte_tokenizer;
	import jbt_pkg::*;

	localparam int          QUIET_LIMIT = 4000;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 20;
	localparam logic [63:0] INT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] OVF_MARK    = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_SPACE,
		SCAN_NUMBER,
		SCAN_STRING,
		SCAN_KEYWORD
	} scan_mode_e;

	logic clk;
	logic arst_n;

	jbt_byte_if  text_in_if ();
	jbt_token_if token_out_if ();

	json_byte_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in_if),
		.token_out (token_out_if)
	);

	// lexer state mirror
	scan_mode_e  mode;
	logic [31:0] byte_pos;
	logic [31:0] tok_origin;
	logic [63:0] acc;
	logic        frac_seen;
	logic [1:0]  kw_choice;
	logic [3:0]  kw_index;
	logic        skipping;

	token_t pending_tokens[$];

	int  src_idle_pct;
	int  snk_idle_pct;
	int  bytes_sent;
	int  check_failures;
	int  quiet_cycles;
	bit  hold_req;

	always #10 clk = ~clk;

	function automatic logic is_blank(logic [7:0] b);
		return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic is_numeral(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic string kw_word(logic [1:0] c);
		case (c)
			KW_TRUE:  return "true";
			KW_FALSE: return "false";
			KW_NULL:  return "null";
			default:  return "undefined";
		endcase
	endfunction

	function automatic logic [3:0] kw_token_kind(logic [1:0] c);
		case (c)
			KW_TRUE, KW_FALSE: return K_BOOL;
			KW_NULL:           return K_NULL;
			default:           return K_UNDEF;
		endcase
	endfunction

	function automatic logic [31:0] span_now();
		return byte_pos - tok_origin;
	endfunction

	task automatic reset_lexer();
		mode = SCAN_IDLE;
		byte_pos = '0;
		tok_origin = '0;
		acc = '0;
		frac_seen = 1'b0;
		kw_choice = KW_TRUE;
		kw_index = '0;
		skipping = 1'b0;
	endtask

	task automatic emit(input logic [3:0] kind, input logic [31:0] start,
			input logic [31:0] len, input logic [63:0] val, input logic frac,
			input logic bv);
		token_t t;
		t.kind = kind;
		t.start = start;
		t.length = len;
		t.value = val;
		t.frac = frac;
		t.bval = bv;
		t.last = 1'b0;
		pending_tokens.push_back(t);
	endtask

	task automatic close_text();
		emit(K_END, byte_pos, 32'd0, 64'd0, 1'b0, 1'b0);
		reset_lexer();
	endtask

	task automatic raise_error(input logic [31:0] len, input logic [7:0] b);
		emit(K_ERROR, tok_origin, len, 64'd0, 1'b0, 1'b0);
		mode = SCAN_IDLE;
		if (b == CH_NUL) begin
			close_text();
		end else begin
			skipping = 1'b1;
			byte_pos = byte_pos + 1;
		end
	endtask

	task automatic scan_byte(input logic [7:0] b);
		string       word;
		logic [63:0] d;
		if (skipping) begin
			if (b == CH_NUL)
				close_text();
			else
				byte_pos = byte_pos + 1;
			return;
		end
		case (mode)
			SCAN_SPACE: begin
				if (is_blank(b)) begin
					byte_pos = byte_pos + 1;
					return;
				end
				emit(K_SPACE, tok_origin, span_now(), 64'd0, 1'b0, 1'b0);
			end
			SCAN_NUMBER: begin
				if (is_numeral(b)) begin
					if (!frac_seen && !acc[63]) begin
						d = 64'(b - CH_ZERO);
						if (acc > (INT_MAX - d) / 64'd10)
							acc = OVF_MARK;
						else
							acc = acc * 64'd10 + d;
					end
					byte_pos = byte_pos + 1;
					return;
				end
				if (b == CH_DOT && !frac_seen) begin
					frac_seen = 1'b1;
					byte_pos = byte_pos + 1;
					return;
				end
				if (frac_seen) begin
					emit(K_NUMBER, tok_origin, span_now(), 64'd0, 1'b1, 1'b0);
				end else if (acc[63]) begin
					// overflowed integer: error covers the digits only
					raise_error(span_now(), b);
					return;
				end else begin
					emit(K_NUMBER, tok_origin, span_now(), acc, 1'b0, 1'b0);
				end
			end
			SCAN_STRING: begin
				if (b == CH_QUOTE) begin
					emit(K_STRING, tok_origin, span_now() + 1, 64'd0, 1'b0, 1'b0);
					mode = SCAN_IDLE;
					byte_pos = byte_pos + 1;
					return;
				end
				if (b == CH_NUL) begin
					raise_error(span_now(), b);
					return;
				end
				byte_pos = byte_pos + 1;
				return;
			end
			SCAN_KEYWORD: begin
				word = kw_word(kw_choice);
				if (kw_index < word.len() && b == word[kw_index]) begin
					kw_index = kw_index + 1;
					if (kw_index >= word.len()) begin
						emit(kw_token_kind(kw_choice), tok_origin, span_now() + 1, 64'd0,
							1'b0, kw_choice == KW_TRUE);
						mode = SCAN_IDLE;
					end
					byte_pos = byte_pos + 1;
					return;
				end
				raise_error((b == CH_NUL) ? span_now() : span_now() + 1, b);
				return;
			end
			default: ;
		endcase

		// this byte opens a new token
		mode = SCAN_IDLE;
		tok_origin = byte_pos;
		if (b == CH_NUL) begin
			close_text();
			return;
		end
		if (is_blank(b)) begin
			mode = SCAN_SPACE;
		end else if (is_numeral(b)) begin
			mode = SCAN_NUMBER;
			acc = 64'(b - CH_ZERO);
			frac_seen = 1'b0;
		end else if (b == CH_LBRACK) begin
			emit(K_LBRACK, byte_pos, 32'd1, 64'd0, 1'b0, 1'b0);
		end else if (b == CH_RBRACK) begin
			emit(K_RBRACK, byte_pos, 32'd1, 64'd0, 1'b0, 1'b0);
		end else if (b == CH_LBRACE) begin
			emit(K_LBRACE, byte_pos, 32'd1, 64'd0, 1'b0, 1'b0);
		end else if (b == CH_RBRACE) begin
			emit(K_RBRACE, byte_pos, 32'd1, 64'd0, 1'b0, 1'b0);
		end else if (b == CH_COMMA) begin
			emit(K_COMMA, byte_pos, 32'd1, 64'd0, 1'b0, 1'b0);
		end else if (b == CH_COLON) begin
			emit(K_COLON, byte_pos, 32'd1, 64'd0, 1'b0, 1'b0);
		end else if (b == CH_QUOTE) begin
			mode = SCAN_STRING;
		end else if (b == CH_T || b == CH_F || b == CH_N || b == CH_U) begin
			mode = SCAN_KEYWORD;
			kw_choice = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE :
				(b == CH_N) ? KW_NULL : KW_UNDEF;
			kw_index = 4'd1;
		end else begin
			raise_error(32'd1, b);
			return;
		end
		byte_pos = byte_pos + 1;
	endtask

	task automatic lex_byte(input logic [7:0] b);
		int     n0;
		token_t t;
		n0 = pending_tokens.size();
		scan_byte(b);
		if (pending_tokens.size() > n0) begin
			t = pending_tokens.pop_back();
			t.last = 1'b1;
			pending_tokens.push_back(t);
		end
	endtask

	// predict on every byte transfer
	always @(posedge clk) begin
		if (arst_n && text_in_if.valid && text_in_if.ready)
			lex_byte(text_in_if.text_byte);
	end

	always @(posedge clk) begin
		token_t want;
		token_t got;
		if (arst_n && token_out_if.valid && token_out_if.ready) begin
			got.kind = token_out_if.token_kind;
			got.start = token_out_if.token_start;
			got.length = token_out_if.token_length;
			got.value = token_out_if.integer_value;
			got.frac = token_out_if.has_fraction;
			got.bval = token_out_if.bool_value;
			got.last = token_out_if.last_result;
			if (pending_tokens.size() == 0) begin
				check_failures++;
				if (check_failures <= 10)
					$display("unexpected token kind=%0d start=%0d len=%0d",
						got.kind, got.start, got.length);
			end else begin
				want = pending_tokens.pop_front();
				if (got.kind !== want.kind || got.start !== want.start ||
						got.length !== want.length || got.value !== want.value ||
						got.frac !== want.frac || got.bval !== want.bval ||
						got.last !== want.last) begin
					check_failures++;
					if (check_failures <= 10) begin
						$display("token mismatch: want kind=%0d start=%0d len=%0d val=%0d",
							want.kind, want.start, want.length, want.value);
						$display("  want frac=%0b bool=%0b last=%0b",
							want.frac, want.bval, want.last);
						$display("  got kind=%0d start=%0d len=%0d val=%0d",
							got.kind, got.start, got.length, got.value);
						$display("  got frac=%0b bool=%0b last=%0b",
							got.frac, got.bval, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((text_in_if.valid && text_in_if.ready) ||
				(token_out_if.valid && token_out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// token sink: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		token_out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
					token_out_if.ready <= 1'b0;
					@(negedge clk);
				end
			end
			token_out_if.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			text_in_if.valid <= 1'b0;
			@(negedge clk);
		end
		text_in_if.valid <= 1'b1;
		text_in_if.text_byte <= b;
		@(posedge clk);
		while (!text_in_if.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// drop valid, then wait until every predicted token is back
	task automatic drain_tokens();
		@(negedge clk);
		text_in_if.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_structural_tokens();
		send_text("{\"ab\":[ 1,2.5]}\t\r\n\"\"");
		send_byte(CH_NUL);
		drain_tokens();
	endtask

	task automatic test_keywords();
		send_text("true false null undefined");
		send_byte(CH_NUL);
		drain_tokens();
	endtask

	task automatic test_number_limits();
		send_text("9223372036854775807 7. 9223372036854775808 ");
		send_byte(CH_NUL);
		send_text("1.2.3]");
		send_byte(CH_NUL);
		drain_tokens();
	endtask

	task automatic test_malformed_text();
		send_text("trux");
		send_byte(8'hFF);
		send_byte(CH_NUL);
		send_text("nul");
		send_byte(CH_NUL);
		send_text("\"open");
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_text("-,");
		send_byte(CH_NUL);
		drain_tokens();
	endtask

	task automatic send_random_token();
		int    pick;
		int    n;
		string word;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 14) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				case ($urandom_range(3))
					0: send_byte(CH_SP);
					1: send_byte(CH_TAB);
					2: send_byte(CH_CR);
					default: send_byte(CH_LF);
				endcase
			end
		end else if (pick < 34) begin
			case ($urandom_range(5))
				0: send_byte(CH_LBRACK);
				1: send_byte(CH_RBRACK);
				2: send_byte(CH_LBRACE);
				3: send_byte(CH_RBRACE);
				4: send_byte(CH_COMMA);
				default: send_byte(CH_COLON);
			endcase
		end else if (pick < 54) begin
			// mostly short numbers; long ones land near or past the int64 limit
			n = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6);
			repeat (n)
				send_byte(CH_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(3) == 0) begin
				send_byte(CH_DOT);
				repeat ($urandom_range(3))
					send_byte(CH_ZERO + 8'($urandom_range(9)));
			end
		end else if (pick < 66) begin
			send_byte(CH_QUOTE);
			repeat ($urandom_range(6)) begin
				c = 8'($urandom_range(1, 255));
				send_byte((c == CH_QUOTE) ? CH_SP : c);
			end
			send_byte(CH_QUOTE);
		end else if (pick < 82) begin
			word = kw_word(2'($urandom_range(3)));
			send_text(word);
		end else if (pick < 90) begin
			// keyword cut short by a wrong letter or end of text
			word = kw_word(2'($urandom_range(3)));
			n = $urandom_range(1, word.len() - 1);
			for (int i = 0; i < n; i++)
				send_byte(word[i]);
			send_byte(($urandom_range(2) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
		end else if (pick < 95) begin
			send_byte(8'($urandom_range(255)));
		end else begin
			send_byte(CH_NUL);
		end
	endtask

	task automatic test_random_texts(input int src_pct, input int snk_pct, input int count);
		int target;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		target = bytes_sent + count;
		while (bytes_sent < target)
			send_random_token();
		send_byte(CH_NUL);
		drain_tokens();
	endtask

	// sink holds off while punctuation keeps arriving: queue fills, input stalls
	task automatic test_output_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req = 1'b1;
		repeat (10)
			send_text("[ ]{,}:");
		send_byte(CH_NUL);
		drain_tokens();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		text_in_if.valid = 1'b0;
		text_in_if.text_byte = CH_NUL;
		src_idle_pct = 23;
		snk_idle_pct = 52;
		bytes_sent = 0;
		check_failures = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		reset_lexer();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_structural_tokens();
		test_keywords();
		test_number_limits();
		test_malformed_text();
		test_random_texts(23, 52, 500);
		test_random_texts(52, 23, 500);
		test_random_texts(0, 0, 500);
		test_output_backpressure();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (check_failures == 0 && pending_tokens.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: json_byte_tokenizer.f
rtl/jbt_pkg.sv
rtl/jbt_byte_if.sv
rtl/jbt_token_if.sv
rtl/jbt_lexer.sv
rtl/jbt_token_fifo.sv
rtl/json_byte_tokenizer.sv
bench/tb_json_byte_tokenizer.sv
